>>> src/bis_pkg.sv
// Shared types and constants of the bilinear image scaler.
// No dependencies; every other file of the block but bis_ram imports this package.
package bis_pkg;

    localparam int COORD_BITS = 12;
    localparam int STEP_BITS  = 24;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_BITS  = 9;
    localparam int CHAN_BITS  = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_BITS   = CHAN_BITS * NUM_CHAN;
    localparam int FRAC_ONE   = 65536;
    localparam int REG_BITS   = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [REG_BITS-1:0] REG_X_STEP     = 2'd0;
    localparam logic [REG_BITS-1:0] REG_Y_STEP     = 2'd1;
    localparam logic [REG_BITS-1:0] REG_SRC_WIDTH  = 2'd2;
    localparam logic [REG_BITS-1:0] REG_SRC_HEIGHT = 2'd3;

    // Sample in flight between the fetch stage and the blend stage.
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] dcol;
        logic [COORD_BITS-1:0] drow;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic                  x0_odd;
        logic                  x1_odd;
        logic                  y0_odd;
        logic                  y1_odd;
    } samp_tag_t;

    // Neighbors in the order top left, top right, bottom left, bottom right.
    typedef logic [3:0][PIX_BITS-1:0] quad_pix_t;

endpackage

>>> src/bis_if.sv
// Request and result channel interfaces of the bilinear image scaler.
// Depends on bis_pkg for the field widths.
interface bis_req_if import bis_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] line;
    logic [CHAN_BITS-1:0]  chan0_in;
    logic [CHAN_BITS-1:0]  chan1_in;
    logic [CHAN_BITS-1:0]  chan2_in;

    modport source (output valid, operation, column, line, chan0_in, chan1_in, chan2_in,
                    input ready);
    modport sink (input valid, operation, column, line, chan0_in, chan1_in, chan2_in,
                  output ready);
endinterface

interface bis_res_if import bis_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] dest_column;
    logic [COORD_BITS-1:0] dest_line;
    logic [CHAN_BITS-1:0]  chan0_out;
    logic [CHAN_BITS-1:0]  chan1_out;
    logic [CHAN_BITS-1:0]  chan2_out;

    modport source (output valid, dest_column, dest_line, chan0_out, chan1_out, chan2_out,
                    input ready);
    modport sink (input valid, dest_column, dest_line, chan0_out, chan1_out, chan2_out,
                  output ready);
endinterface

>>> src/bis_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bis_cfg.sv
// Configuration registers of the bilinear image scaler; sizes are stored as
// clamped last indices. Depends on bis_pkg.
module bis_cfg import bis_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_enable,
    input  logic [REG_BITS-1:0]               reg_index,
    input  logic [STEP_BITS-1:0]              write_data,
    output logic [STEP_BITS-1:0]              x_step,
    output logic [STEP_BITS-1:0]              y_step,
    output logic [$clog2(MAX_SRC_WIDTH)-1:0]  last_col,
    output logic [$clog2(MAX_SRC_HEIGHT)-1:0] last_line
);

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int RST_LAST_COL  = (MAX_SRC_WIDTH < 256 ? MAX_SRC_WIDTH : 256) - 1;
    localparam int RST_LAST_LINE = (MAX_SRC_HEIGHT < 256 ? MAX_SRC_HEIGHT : 256) - 1;

    logic [STEP_BITS-1:0] x_step_reg, x_step_next;
    logic [STEP_BITS-1:0] y_step_reg, y_step_next;
    logic [XW-1:0]        last_col_reg, last_col_next;
    logic [YW-1:0]        last_line_reg, last_line_next;
    logic [SIZE_BITS-1:0] size_val;
    logic [XW-1:0]        size_last_col;
    logic [YW-1:0]        size_last_line;

    // A size of zero acts as one, a size beyond the store acts as the maximum.
    always_comb
    begin
        size_val = write_data[SIZE_BITS-1:0];
        if (size_val == '0)
        begin
            size_last_col  = '0;
            size_last_line = '0;
        end
        else
        begin
            size_last_col  = (13'(size_val) > 13'(MAX_SRC_WIDTH)) ? XW'(MAX_SRC_WIDTH - 1)
                                                                  : XW'(size_val - 9'd1);
            size_last_line = (13'(size_val) > 13'(MAX_SRC_HEIGHT)) ? YW'(MAX_SRC_HEIGHT - 1)
                                                                   : YW'(size_val - 9'd1);
        end
    end

    always_comb
    begin
        x_step_next    = x_step_reg;
        y_step_next    = y_step_reg;
        last_col_next  = last_col_reg;
        last_line_next = last_line_reg;
        if (write_enable)
        begin
            case (reg_index)
                REG_X_STEP:     x_step_next    = write_data;
                REG_Y_STEP:     y_step_next    = write_data;
                REG_SRC_WIDTH:  last_col_next  = size_last_col;
                REG_SRC_HEIGHT: last_line_next = size_last_line;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg    <= STEP_BITS'(FRAC_ONE);
            y_step_reg    <= STEP_BITS'(FRAC_ONE);
            last_col_reg  <= XW'(RST_LAST_COL);
            last_line_reg <= YW'(RST_LAST_LINE);
        end
        else
        begin
            x_step_reg    <= x_step_next;
            y_step_reg    <= y_step_next;
            last_col_reg  <= last_col_next;
            last_line_reg <= last_line_next;
        end
    end

    assign x_step    = x_step_reg;
    assign y_step    = y_step_reg;
    assign last_col  = last_col_reg;
    assign last_line = last_line_reg;

endmodule

>>> src/bis_fetch.sv
// Coordinate mapping and the four-bank frame store: loads write one bank,
// samples read all four neighbors at once. Depends on bis_pkg, bis_if, bis_ram.
module bis_fetch import bis_pkg::*; #(
    parameter int MAX_SRC_WIDTH   = 256,
    parameter int MAX_SRC_HEIGHT  = 256,
    parameter int DEST_COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    bis_req_if.sink                           request,
    input  logic [STEP_BITS-1:0]              x_step,
    input  logic [STEP_BITS-1:0]              y_step,
    input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  last_col,
    input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] last_line,
    output samp_tag_t                         tag,
    output quad_pix_t                         pix
);

    localparam int XW         = $clog2(MAX_SRC_WIDTH);
    localparam int YW         = $clog2(MAX_SRC_HEIGHT);
    localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BAW        = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
    localparam int PW         = COORD_BITS + STEP_BITS;
    localparam int IXW        = PW - FRAC_BITS;
    localparam logic [COORD_BITS-1:0] COORD_MASK =
        (DEST_COORD_BITS >= COORD_BITS) ? {COORD_BITS{1'b1}}
                                        : COORD_BITS'((1 << DEST_COORD_BITS) - 1);

    logic                  accept;
    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [COORD_BITS-1:0] s1_col_reg;
    logic [COORD_BITS-1:0] s1_row_reg;
    logic [PW-1:0]         s1_sx_reg, s1_sx_next;
    logic [PW-1:0]         s1_sy_reg, s1_sy_next;
    logic [PIX_BITS-1:0]   s1_px_reg;
    logic [IXW-1:0]        ix, iy;
    logic [IXW:0]          ix1, iy1;
    logic [XW-1:0]         x0, x1;
    logic [YW-1:0]         y0, y1;
    logic [XW-1:0]         wcol;
    logic [YW-1:0]         wrow;
    logic                  load_ok;
    logic [BAW-1:0]        waddr;
    logic [3:0]            bank_we;
    quad_pix_t             bank_rd;
    samp_tag_t             tag_reg, tag_next;

    assign accept        = request.valid && advance;
    assign request.ready = advance;

    always_comb
    begin
        s1_sx_next = PW'(request.column & COORD_MASK) * PW'(x_step);
        s1_sy_next = PW'(request.line & COORD_MASK) * PW'(y_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg  <= request.operation;
            s1_col_reg <= request.column;
            s1_row_reg <= request.line;
            s1_sx_reg  <= s1_sx_next;
            s1_sy_reg  <= s1_sy_next;
            s1_px_reg  <= {request.chan2_in, request.chan1_in, request.chan0_in};
        end
    end

    // Neighbor indices, clamped to the last column and line of the image.
    always_comb
    begin
        ix  = s1_sx_reg[PW-1:FRAC_BITS];
        iy  = s1_sy_reg[PW-1:FRAC_BITS];
        ix1 = (IXW+1)'(ix) + 1'b1;
        iy1 = (IXW+1)'(iy) + 1'b1;
        x0  = (ix > IXW'(last_col)) ? last_col : XW'(ix);
        x1  = (ix1 > (IXW+1)'(last_col)) ? last_col : XW'(ix1);
        y0  = (iy > IXW'(last_line)) ? last_line : YW'(iy);
        y1  = (iy1 > (IXW+1)'(last_line)) ? last_line : YW'(iy1);
    end

    always_comb
    begin
        wcol    = XW'(s1_col_reg);
        wrow    = YW'(s1_row_reg);
        load_ok = s1_valid_reg && (s1_op_reg == OP_LOAD)
                  && (13'(s1_col_reg) < 13'(MAX_SRC_WIDTH))
                  && (13'(s1_row_reg) < 13'(MAX_SRC_HEIGHT));
        waddr   = BAW'(wrow >> 1) * BAW'(HALF_W) + BAW'(wcol >> 1);
    end

    // Bank index is {row parity, column parity}. Two distinct neighbors in
    // one direction always differ in parity, so each bank serves one of them.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);
        logic [XW-1:0]  rcol;
        logic [YW-1:0]  rrow;
        logic [BAW-1:0] raddr;

        assign rcol       = (x0[0] == BX) ? x0 : x1;
        assign rrow       = (y0[0] == BY) ? y0 : y1;
        assign raddr      = BAW'(rrow >> 1) * BAW'(HALF_W) + BAW'(rcol >> 1);
        assign bank_we[b] = load_ok && advance && (wcol[0] == BX) && (wrow[0] == BY);

        bis_ram #(
            .WIDTH (PIX_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (s1_px_reg),
            .re    (advance),
            .raddr (raddr),
            .rdata (bank_rd[b])
        );
    end

    always_comb
    begin
        tag_next.valid  = s1_valid_reg && (s1_op_reg == OP_SAMPLE);
        tag_next.dcol   = s1_col_reg & COORD_MASK;
        tag_next.drow   = s1_row_reg & COORD_MASK;
        tag_next.fx     = s1_sx_reg[FRAC_BITS-1:0];
        tag_next.fy     = s1_sy_reg[FRAC_BITS-1:0];
        tag_next.x0_odd = x0[0];
        tag_next.x1_odd = x1[0];
        tag_next.y0_odd = y0[0];
        tag_next.y1_odd = y1[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= tag_next;
        end
    end

    assign tag    = tag_reg;
    assign pix[0] = bank_rd[{tag_reg.y0_odd, tag_reg.x0_odd}];
    assign pix[1] = bank_rd[{tag_reg.y0_odd, tag_reg.x1_odd}];
    assign pix[2] = bank_rd[{tag_reg.y1_odd, tag_reg.x0_odd}];
    assign pix[3] = bank_rd[{tag_reg.y1_odd, tag_reg.x1_odd}];

`ifndef SYNTHESIS
    a_neighbor_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_op_reg == OP_SAMPLE) |-> (x0 <= last_col) && (y0 <= last_line))
        else $error("neighbor index beyond the image");

    a_neighbor_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_op_reg == OP_SAMPLE)
        |-> ((x1 == x0) || (x1 == x0 + 1'b1)) && ((y1 == y0) || (y1 == y0 + 1'b1)))
        else $error("right or lower neighbor not adjacent");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("load wrote more than one bank");

    a_sample_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && (s1_op_reg == OP_SAMPLE) |=> tag_reg.valid)
        else $error("sample lost between mapping and blend");
`endif

endmodule

>>> src/bis_blend.sv
// Bilinear blend: horizontal weighting of both neighbor rows, then vertical
// weighting and truncation into the output register. Depends on bis_pkg, bis_if.
module bis_blend import bis_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  samp_tag_t tag,
    input  quad_pix_t pix,
    bis_res_if.source result
);

    localparam int WB = FRAC_BITS + 1;
    localparam int AB = FRAC_BITS + CHAN_BITS;
    localparam int PB = WB + AB;

    logic                              s3_valid_reg;
    logic [COORD_BITS-1:0]             s3_dcol_reg, s3_drow_reg;
    logic [FRAC_BITS-1:0]              s3_fy_reg;
    logic [NUM_CHAN-1:0][AB-1:0]       s3_top_reg, s3_top_next;
    logic [NUM_CHAN-1:0][AB-1:0]       s3_bot_reg, s3_bot_next;
    logic [WB-1:0]                     wx0, wy0;
    logic [PB-1:0]                     acc;
    logic                              out_valid_reg;
    logic [COORD_BITS-1:0]             out_col_reg, out_line_reg;
    logic [NUM_CHAN-1:0][CHAN_BITS-1:0] out_chan_reg, out_chan_next;

    // Exact sums: top and bottom rows stay below 2^24.
    always_comb
    begin
        wx0 = WB'(FRAC_ONE) - WB'(tag.fx);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            s3_top_next[c] = AB'((AB+1)'(wx0) * (AB+1)'(pix[0][c*CHAN_BITS +: CHAN_BITS])
                               + (AB+1)'(tag.fx) * (AB+1)'(pix[1][c*CHAN_BITS +: CHAN_BITS]));
            s3_bot_next[c] = AB'((AB+1)'(wx0) * (AB+1)'(pix[2][c*CHAN_BITS +: CHAN_BITS])
                               + (AB+1)'(tag.fx) * (AB+1)'(pix[3][c*CHAN_BITS +: CHAN_BITS]));
        end
    end

    always_comb
    begin
        wy0 = WB'(FRAC_ONE) - WB'(s3_fy_reg);
        acc = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc = PB'(wy0) * PB'(s3_top_reg[c]) + PB'(s3_fy_reg) * PB'(s3_bot_reg[c]);
            out_chan_next[c] = acc[2*FRAC_BITS +: CHAN_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg  <= tag.valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_dcol_reg  <= tag.dcol;
            s3_drow_reg  <= tag.drow;
            s3_fy_reg    <= tag.fy;
            s3_top_reg   <= s3_top_next;
            s3_bot_reg   <= s3_bot_next;
            out_col_reg  <= s3_dcol_reg;
            out_line_reg <= s3_drow_reg;
            out_chan_reg <= out_chan_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.dest_column = out_col_reg;
    assign result.dest_line   = out_line_reg;
    assign result.chan0_out   = out_chan_reg[0];
    assign result.chan1_out   = out_chan_reg[1];
    assign result.chan2_out   = out_chan_reg[2];

endmodule

>>> src/bilinear_image_scaler_unit.sv
// Bilinear image scaler: request beats either load one source pixel into the
// frame store (operation 0) or sample one destination pixel (operation 1).
// A sample gives one result beat with its destination coordinates and the
// three interpolated channels; a load gives none.
// The frame store is split into four banks by column and row parity, so the
// four neighbors of a sample are read together and one beat is taken every
// cycle while the receiver does not stall. A sample passes in order through the
// mapping multiply, bank read, horizontal blend and vertical blend registers.
// A load takes effect for every beat accepted after it.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// request.ready drops; ready is high whenever the output register is empty or
// being taken.
// Reset clears all valid flags and restores the step and size registers; the
// frame store is not cleared and must be loaded before it is sampled.
// Configuration writes are taken at any clock edge with write_enable high and
// belong only in idle periods.
// Depends on bis_pkg, bis_if, bis_cfg, bis_fetch, bis_blend and bis_ram.
module bilinear_image_scaler_unit import bis_pkg::*; #(
    parameter int MAX_SRC_WIDTH   = 256,
    parameter int MAX_SRC_HEIGHT  = 256,
    parameter int DEST_COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bis_req_if.sink              request,
    bis_res_if.source            result,
    input  logic                 write_enable,
    input  logic [REG_BITS-1:0]  reg_index,
    input  logic [STEP_BITS-1:0] write_data
);

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);

    logic                 advance;
    logic [STEP_BITS-1:0] x_step, y_step;
    logic [XW-1:0]        last_col;
    logic [YW-1:0]        last_line;
    samp_tag_t            tag;
    quad_pix_t            pix;

    assign advance = !result.valid || result.ready;

    bis_cfg #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .x_step       (x_step),
        .y_step       (y_step),
        .last_col     (last_col),
        .last_line    (last_line)
    );

    bis_fetch #(
        .MAX_SRC_WIDTH   (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT  (MAX_SRC_HEIGHT),
        .DEST_COORD_BITS (DEST_COORD_BITS)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .request   (request),
        .x_step    (x_step),
        .y_step    (y_step),
        .last_col  (last_col),
        .last_line (last_line),
        .tag       (tag),
        .pix       (pix)
    );

    bis_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tag     (tag),
        .pix     (pix),
        .result  (result)
    );

endmodule
